>>> design/cvh_pkg.sv
// Shared types, constants and request/status codes for the convex hull point check.
// No dependencies; every other design file takes names from here by scope.

package cvh_pkg;

   // Table depth and the widths that follow from it
   localparam int MAX_PLANES = 16;
   localparam int CNT_W      = $clog2(MAX_PLANES + 1);
   localparam int IDX_W      = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

   // Fixed-point widths
   localparam int COORD_W = 24;                 // Q8.16
   localparam int PROD_W  = 2 * COORD_W;        // Q16.32 product
   localparam int OFF_SH  = 16;                 // offset aligned to 2^-32
   localparam int PAIR_W  = PROD_W + 1;
   localparam int SUM_W   = PROD_W + 2;

   // Request codes
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   // Status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOPLANES = 2'd2;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic signed [COORD_W-1:0]  normal_x;
      logic signed [COORD_W-1:0]  normal_y;
      logic signed [COORD_W-1:0]  normal_z;
      logic signed [COORD_W-1:0]  plane_offset;
      logic signed [COORD_W-1:0]  point_x;
      logic signed [COORD_W-1:0]  point_y;
      logic signed [COORD_W-1:0]  point_z;
   } req_item_type;

   typedef struct packed {
      logic       inside_res;
      logic [1:0] status;
   } rsp_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] normal_x;
      logic signed [COORD_W-1:0] normal_y;
      logic signed [COORD_W-1:0] normal_z;
      logic signed [COORD_W-1:0] plane_offset;
   } plane_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } point_type;

   // Plane table access from the sequencer
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_ctrl_type;

   // Dot-product unit status back to the sequencer
   typedef struct packed {
      logic busy;
      logic neg_seen;
   } dot_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_RESP
   } state_type;

endpackage

>>> design/cvh_plane_mem.sv
// Plane table: one write port, one registered read port, no reset on the entries.
// Depends on cvh_pkg for the plane type and table depth.

module cvh_plane_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  cvh_pkg::mem_ctrl_type ctrl,
   input  cvh_pkg::plane_type    wr_data,
   output cvh_pkg::plane_type    rd_data,
   output logic                  rd_valid
);

   cvh_pkg::plane_type mem_ff [cvh_pkg::MAX_PLANES];
   cvh_pkg::plane_type rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[ctrl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctrl.rd_en;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

>>> design/cvh_dot_unit.sv
// Pipelined plane test: n.p + d*2^16, one plane per cycle, sticky negative flag.
// Depends on cvh_pkg for plane/point types and fixed-point widths.

module cvh_dot_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  in_valid,
   input  cvh_pkg::plane_type    plane,
   input  cvh_pkg::point_type    point,
   output cvh_pkg::dot_stat_type stat
);

   localparam int PW = cvh_pkg::PROD_W;
   localparam int AW = cvh_pkg::PAIR_W;
   localparam int SW = cvh_pkg::SUM_W;

   // stage 1: three products and the aligned offset
   logic signed [PW-1:0] prod_x_ff, prod_y_ff, prod_z_ff, off_ff;
   logic signed [PW-1:0] prod_x_in, prod_y_in, prod_z_in, off_in;
   // stage 2: pair sums
   logic signed [AW-1:0] pair_a_ff, pair_b_ff, pair_a_in, pair_b_in;
   // stage 3: total and sign
   logic signed [SW-1:0] total;
   logic                 v1_ff, v2_ff, neg_ff, neg_in;

   always_comb begin
      prod_x_in = PW'(plane.normal_x) * PW'(point.point_x);
      prod_y_in = PW'(plane.normal_y) * PW'(point.point_y);
      prod_z_in = PW'(plane.normal_z) * PW'(point.point_z);
      off_in    = PW'(plane.plane_offset) <<< cvh_pkg::OFF_SH;
      pair_a_in = AW'(prod_x_ff) + AW'(prod_y_ff);
      pair_b_in = AW'(prod_z_ff) + AW'(off_ff);
      total     = SW'(pair_a_ff) + SW'(pair_b_ff);
      if (start) begin
         neg_in = 1'b0;
      end else begin
         neg_in = neg_ff | (v2_ff & total[SW-1]);
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      off_ff    <= off_in;
      pair_a_ff <= pair_a_in;
      pair_b_ff <= pair_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         neg_ff <= 1'b0;
      end else begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         neg_ff <= neg_in;
      end
   end

   assign stat.busy     = in_valid | v1_ff | v2_ff;
   assign stat.neg_seen = neg_ff;

endmodule

>>> design/convex_hull_point_check.sv
// Convex hull point check: geofence over a table of up to MAX_PLANES (16) half-space planes.
// Each request transaction clears the table, appends a plane, or tests a point; every request
// gives exactly one response transaction. Clear, append and unknown request codes raise
// response valid in the cycle after acceptance. In a query the sequencer reads one plane
// per cycle from the plane table (separate read and write ports) into one pipelined
// dot-product unit (table read, three products, pair sums, final sum and sign), then waits
// for the pipeline to drain. The block takes one transaction at a time; req_ready is low
// until the response has been taken. Depends on cvh_pkg, cvh_plane_mem and cvh_dot_unit.

module convex_hull_point_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cvh_pkg::req_item_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cvh_pkg::rsp_item_type rsp_payload
);

   localparam int CW = cvh_pkg::CNT_W;
   localparam int IW = cvh_pkg::IDX_W;

   cvh_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  planes_valid_ff, planes_valid_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   cvh_pkg::point_type    point_ff, point_in;
   cvh_pkg::rsp_item_type rsp_ff, rsp_in;

   cvh_pkg::mem_ctrl_type mem_ctrl;
   cvh_pkg::plane_type    wr_plane, rd_plane;
   cvh_pkg::dot_stat_type dot_stat;
   logic                  rd_valid;
   logic                  dot_start;

   logic accept;
   logic table_full;
   logic query_go;
   logic last_issue;

   assign accept     = req_valid & req_ready;
   assign table_full = (count_ff >= CW'(cvh_pkg::MAX_PLANES));
   // a query runs the planes only when something has been loaded since the last clear
   assign query_go   = (req_payload.req_type == cvh_pkg::REQ_QUERY)
                     & planes_valid_ff & (count_ff != '0);
   assign last_issue = ((rd_idx_ff + CW'(1)) == count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cvh_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = query_go ? cvh_pkg::ST_RUN : cvh_pkg::ST_RESP;
            end
         end
         cvh_pkg::ST_RUN: begin
            if (last_issue) begin
               state_in = cvh_pkg::ST_DRAIN;
            end
         end
         cvh_pkg::ST_DRAIN: begin
            if (!dot_stat.busy) begin
               state_in = cvh_pkg::ST_RESP;
            end
         end
         cvh_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = cvh_pkg::ST_IDLE;
            end
         end
         default: state_in = cvh_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath next values
   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      dot_start        = 1'b0;
      mem_ctrl.wr_en   = 1'b0;
      mem_ctrl.wr_addr = count_ff[IW-1:0];
      mem_ctrl.rd_en   = 1'b0;
      mem_ctrl.rd_addr = rd_idx_ff[IW-1:0];
      count_in         = count_ff;
      planes_valid_in  = planes_valid_ff;
      rd_idx_in        = rd_idx_ff;
      point_in         = point_ff;
      rsp_in           = rsp_ff;
      unique case (state_ff)
         cvh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               rsp_in.inside_res = 1'b0;
               rsp_in.status     = cvh_pkg::STAT_OK;
               rd_idx_in         = '0;
               dot_start         = 1'b1;
               point_in.point_x  = req_payload.point_x;
               point_in.point_y  = req_payload.point_y;
               point_in.point_z  = req_payload.point_z;
               case (req_payload.req_type)
                  cvh_pkg::REQ_CLEAR: begin
                     count_in        = '0;
                     planes_valid_in = 1'b0;
                  end
                  cvh_pkg::REQ_APPEND: begin
                     if (table_full) begin
                        rsp_in.status = cvh_pkg::STAT_FULL;
                     end else begin
                        mem_ctrl.wr_en  = 1'b1;
                        count_in        = count_ff + CW'(1);
                        planes_valid_in = 1'b1;
                     end
                  end
                  cvh_pkg::REQ_QUERY: begin
                     if (!query_go) begin
                        rsp_in.status = cvh_pkg::STAT_NOPLANES;
                     end
                  end
                  default: ;  // unknown code: no state change, plain ok response
               endcase
            end
         end
         cvh_pkg::ST_RUN: begin
            mem_ctrl.rd_en = 1'b1;
            rd_idx_in      = rd_idx_ff + CW'(1);
         end
         cvh_pkg::ST_DRAIN: begin
            // pipeline empty: sticky flag covers every plane issued
            if (!dot_stat.busy) begin
               rsp_in.inside_res = ~dot_stat.neg_seen;
            end
         end
         cvh_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cvh_pkg::ST_IDLE;
         count_ff        <= '0;
         planes_valid_ff <= 1'b0;
         rd_idx_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         planes_valid_ff <= planes_valid_in;
         rd_idx_ff       <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

   assign wr_plane.normal_x     = req_payload.normal_x;
   assign wr_plane.normal_y     = req_payload.normal_y;
   assign wr_plane.normal_z     = req_payload.normal_z;
   assign wr_plane.plane_offset = req_payload.plane_offset;

   cvh_plane_mem u_plane_mem (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mem_ctrl),
      .wr_data  (wr_plane),
      .rd_data  (rd_plane),
      .rd_valid (rd_valid)
   );

   cvh_dot_unit u_dot_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (dot_start),
      .in_valid (rd_valid),
      .plane    (rd_plane),
      .point    (point_ff),
      .stat     (dot_stat)
   );

endmodule

>>> design/cvh_checker.sv
// Port-level checks for convex_hull_point_check, attached by the bind below.
// Depends on cvh_pkg for payload types and status codes.

module cvh_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input cvh_pkg::rsp_item_type rsp_payload
);

   // a waiting response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed or dropped while stalled");

   // one transaction in flight: never ready while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response is pending");

   // an accepted request closes the input until its response is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready straight after a transaction");

   // status is one of the three codes, and inside only comes with an ok status
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == cvh_pkg::STAT_OK ||
                     rsp_payload.status == cvh_pkg::STAT_FULL ||
                     rsp_payload.status == cvh_pkg::STAT_NOPLANES) &&
                    (!rsp_payload.inside_res || rsp_payload.status == cvh_pkg::STAT_OK))
      else $error("illegal response status");

endmodule

bind convex_hull_point_check cvh_checker u_cvh_checker (.*);
